[rtl/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, constants and helpers for the multi-motor step-rate generator.
// ----------------------------------------------------------------------------
package msp_pkg;

    // motor count and mask width shown on the result
    localparam int MOTORS = 2;
    localparam int MASK_W = (MOTORS > 2) ? MOTORS : 2;

    // period formula: 2000000 / 1024 = 15625 / 8
    localparam int NUM_W      = 30;
    localparam int DEN_W      = 20;
    localparam int DIV_STEPS  = NUM_W;
    localparam logic [13:0] NUM_SCALE = 14'd15625;

    // period limits and activation threshold
    localparam logic [15:0] PER_MIN   = 16'd99;
    localparam logic [15:0] PER_MAX   = 16'd65000;
    localparam logic [12:0] SPEED_MIN = 13'd10;

    // register indexes (word address)
    localparam logic [1:0] REG_MICROSTEP_DIV = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED     = 2'd1;
    localparam logic [1:0] REG_DEG_PER_STEP  = 2'd2;
    localparam logic [1:0] REG_TICK_AMOUNT   = 2'd3;

    // configuration register set
    typedef struct packed {
        logic [4:0]  microstep_div;
        logic [11:0] speed_limit;
        logic [15:0] deg_per_step_q10;
        logic [15:0] tick_amount;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_speed;
        logic out_free;
    } t_sts;

    // microstep select pins MS3..MS1 from the divider
    function automatic logic [2:0] mode_pins_of(input logic [4:0] div);
        logic [2:0] pins;
        unique case (div)
            5'd2:    pins = 3'b001;
            5'd4:    pins = 3'b010;
            5'd8:    pins = 3'b011;
            5'd16:   pins = 3'b111;
            default: pins = 3'b000;
        endcase
        return pins;
    endfunction

endpackage

[rtl/multi_stepper_pulse_generator.sv]
// A timer tick goes from acceptance through the prep and done states to the
// result register; a speed command also runs the 30-step restoring period
// divider between them. A new transaction is accepted only in idle, after
// commit; the divider, one quotient bit per cycle, sets the command rate.
// Reset (synchronous, active low) clears motor state and the result valid flag
// and loads register defaults; the block accepts the first cycle after reset.
// ----------------------------------------------------------------------------
// multi_stepper_pulse_generator
// Step and direction generator for several stepper motors, driven by speed
// command and timer tick transactions, with an APB configuration port.
// ----------------------------------------------------------------------------
module multi_stepper_pulse_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic               i_motor_index,
    input  logic signed [12:0] i_speed,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_step_mask,
    output logic [1:0]         o_dir_mask,
    output logic [15:0]        o_period_set,
    output logic [2:0]         o_mode_pins
);
    import msp_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // configuration registers
    msp_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    msp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    msp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_motor_index (i_motor_index),
        .i_speed       (i_speed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_step_mask   (o_step_mask),
        .o_dir_mask    (o_dir_mask),
        .o_period_set  (o_period_set),
        .o_mode_pins   (o_mode_pins)
    );

endmodule

[rtl/msp_apb.sv]
// ----------------------------------------------------------------------------
// msp_apb
// Configuration register file behind a simple APB slave port.
// ----------------------------------------------------------------------------
module msp_apb (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output msp_pkg::t_cfg   o_cfg
);
    import msp_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.microstep_div    <= 5'd1;
            r_cfg.speed_limit      <= 12'd1000;
            r_cfg.deg_per_step_q10 <= 16'd1843;
            r_cfg.tick_amount      <= 16'd99;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MICROSTEP_DIV: r_cfg.microstep_div    <= pwdata[4:0];
                REG_MAX_SPEED:     r_cfg.speed_limit      <= pwdata[11:0];
                REG_DEG_PER_STEP:  r_cfg.deg_per_step_q10 <= pwdata[15:0];
                REG_TICK_AMOUNT:   r_cfg.tick_amount      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_MICROSTEP_DIV: prdata = {27'd0, r_cfg.microstep_div};
            REG_MAX_SPEED:     prdata = {20'd0, r_cfg.speed_limit};
            REG_DEG_PER_STEP:  prdata = {16'd0, r_cfg.deg_per_step_q10};
            REG_TICK_AMOUNT:   prdata = {16'd0, r_cfg.tick_amount};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

[rtl/msp_ctrl.sv]
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer: accepts a transaction, runs the period divider, commits result.
// ----------------------------------------------------------------------------
module msp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  msp_pkg::t_sts i_sts,
    output msp_pkg::t_cmd o_cmd
);
    import msp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid & ~o_in_stall;

    // commands
    always_comb begin
        o_cmd.load     = accept;
        o_cmd.prep     = (r_state == ST_PREP);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.commit   = (r_state == ST_DONE) && i_sts.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_cnt   = '0;
                n_state = i_sts.is_speed ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // accepted transaction always goes through the prep cycle
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_PREP))
        else $error("accepted transaction did not enter prep");

    // a tick skips the divider
    a_tick_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP && !i_sts.is_speed) |=> (r_state == ST_DONE))
        else $error("tick entered the divider");

    // divider leaves only after its last step
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != CNT_W'(DIV_STEPS - 1)) |=> (r_state == ST_DIV))
        else $error("divider left early");

endmodule

[rtl/msp_dp.sv]
// ----------------------------------------------------------------------------
// msp_dp
// Datapath: motor state, period divider, tick update and result register.
// ----------------------------------------------------------------------------
module msp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msp_pkg::t_cfg      i_cfg,
    input  msp_pkg::t_cmd      i_cmd,
    output msp_pkg::t_sts      o_sts,
    input  logic               i_req_type,
    input  logic               i_motor_index,
    input  logic signed [12:0] i_speed,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_step_mask,
    output logic [1:0]         o_dir_mask,
    output logic [15:0]        o_period_set,
    output logic [2:0]         o_mode_pins
);
    import msp_pkg::*;

    // latched transaction
    logic              r_req;
    logic              r_idx;
    logic signed [12:0] r_speed;

    // divider
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic              r_new_active;
    logic              r_new_dir;

    // motor state
    logic [15:0]       r_period [MOTORS];
    logic [15:0]       r_count  [MOTORS];
    logic [MOTORS-1:0] r_active;
    logic [MOTORS-1:0] r_want;
    logic [MOTORS-1:0] r_latch;
    logic [15:0]       n_period [MOTORS];
    logic [15:0]       n_count  [MOTORS];
    logic [MOTORS-1:0] n_active;
    logic [MOTORS-1:0] n_want;
    logic [MOTORS-1:0] n_latch;
    logic [MOTORS-1:0] step_bits;

    // result register
    logic              r_out_valid;
    logic [1:0]        r_step_mask;
    logic [1:0]        r_dir_mask;
    logic [15:0]       r_period_out;
    logic [2:0]        r_mode_pins;

    // prep signals
    logic [12:0]       spd_u;
    logic              neg;
    logic [12:0]       mag13;
    logic              too_slow;
    logic [11:0]       mag;
    logic [16:0]       prod;

    // divider step signals
    logic [DEN_W:0]    rem_sh;
    logic              q_bit;

    logic [15:0]       per;
    logic [15:0]       tick_cnt [MOTORS];
    logic [MASK_W-1:0] step_ext;
    logic [MASK_W-1:0] dir_ext;

    assign o_sts.is_speed = r_req;
    assign o_sts.out_free = ~r_out_valid | ~i_out_stall;

    // speed magnitude, activation and clamp
    always_comb begin
        spd_u    = r_speed;
        neg      = spd_u[12];
        mag13    = neg ? (13'd0 - spd_u) : spd_u;
        too_slow = (mag13 < SPEED_MIN);
        if (too_slow) begin
            mag = 12'd1;
        end else if (mag13 > {1'b0, i_cfg.speed_limit}) begin
            mag = i_cfg.speed_limit;
        end else begin
            mag = mag13[11:0];
        end
        prod = 17'(mag) * 17'(i_cfg.microstep_div);
    end

    // restoring divider step, quotient shifts into the numerator register
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    // clamp quotient, a zero divisor yields all ones and lands on the top
    always_comb begin
        if (r_num < NUM_W'(PER_MIN)) begin
            per = PER_MIN;
        end else if (r_num > NUM_W'(PER_MAX)) begin
            per = PER_MAX;
        end else begin
            per = r_num[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= i_motor_index;
            r_speed <= i_speed;
        end
        if (i_cmd.prep) begin
            r_num        <= NUM_W'(NUM_SCALE) * NUM_W'(i_cfg.deg_per_step_q10);
            r_den        <= {prod, 3'b000};
            r_rem        <= '0;
            r_new_active <= ~too_slow;
            r_new_dir    <= ~neg;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], q_bit};
        end
    end

    // request type steers the controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= 1'b0;
        end else if (i_cmd.load) begin
            r_req <= i_req_type;
        end
    end

    // next motor state for tick or speed command
    always_comb begin
        step_bits = '0;
        for (int m = 0; m < MOTORS; m++) begin
            n_period[m] = r_period[m];
            n_count[m]  = r_count[m];
            n_active[m] = r_active[m];
            n_want[m]   = r_want[m];
            n_latch[m]  = r_latch[m];
            tick_cnt[m] = r_count[m] - i_cfg.tick_amount;
            if (r_req) begin
                if (int'(r_idx) == m) begin
                    n_active[m] = r_new_active;
                    if (r_new_active) n_want[m] = r_new_dir;
                    n_period[m] = per;
                    if (r_count[m] == 16'd0) n_count[m] = per;
                end
            end else begin
                n_count[m] = tick_cnt[m];
                if (tick_cnt[m] < i_cfg.tick_amount) begin
                    n_count[m] = r_period[m];
                    if (r_active[m]) begin
                        step_bits[m] = 1'b1;
                        n_latch[m]   = r_want[m];
                    end
                end
            end
        end
        step_ext = MASK_W'(step_bits);
        dir_ext  = MASK_W'(n_latch);
    end

    // motor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTORS; m++) begin
                r_period[m] <= '0;
                r_count[m]  <= '0;
            end
            r_active <= '0;
            r_want   <= '0;
            r_latch  <= '0;
        end else if (i_cmd.commit) begin
            r_period <= n_period;
            r_count  <= n_count;
            r_active <= n_active;
            r_want   <= n_want;
            r_latch  <= n_latch;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_step_mask  <= step_ext[1:0];
            r_dir_mask   <= dir_ext[1:0];
            r_period_out <= r_req ? per : 16'd0;
            r_mode_pins  <= mode_pins_of(i_cfg.microstep_div);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step_mask  = r_step_mask;
    assign o_dir_mask   = r_dir_mask;
    assign o_period_set = r_period_out;
    assign o_mode_pins  = r_mode_pins;

    // a speed command result always carries a clamped period
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_req) |=> (r_period_out >= PER_MIN && r_period_out <= PER_MAX))
        else $error("speed command period out of range");

    // ticks never report a period
    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_req) |=> (r_period_out == 16'd0))
        else $error("tick reported a period");

    // commit never overwrites an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

[dv/msp_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_tb_pkg
// Request codes shared by the stimulus generator and the result checker.
// ----------------------------------------------------------------------------
package msp_tb_pkg;

    // request kind carried by an input transaction
    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_SPEED = 1'b1
    } t_req;

endpackage

[dv/msp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_checker
// Watches the configuration port and both transaction channels of the step
// generator, keeps its own copy of the motor state, predicts every result
// and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module msp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port, observed only
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    // input channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_req_type,
    input  logic        i_motor_index,
    input  logic [12:0] i_speed,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_step_mask,
    input  logic [1:0]  i_dir_mask,
    input  logic [15:0] i_period_set,
    input  logic [2:0]  i_mode_pins,
    // status for the testbench top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_steps
);
    import msp_pkg::*;
    import msp_tb_pkg::*;

    typedef struct packed {
        logic [1:0]  step_mask;
        logic [1:0]  dir_mask;
        logic [15:0] period_set;
        logic [2:0]  mode_pins;
    } t_motion;

    // shadow of the configuration registers
    logic [4:0]  div_cfg;
    logic [11:0] max_cfg;
    logic [15:0] angle_cfg;
    logic [15:0] tick_cfg;

    // shadow of the per-motor state
    logic [15:0] period_q   [MOTORS];
    logic [15:0] count_q    [MOTORS];
    logic        active_q   [MOTORS];
    logic        want_dir_q [MOTORS];
    logic        pin_dir_q  [MOTORS];

    t_motion pending_motion[$];
    int      fails   = 0;
    int      checked = 0;
    int      steps   = 0;

    // count a failure, report only the first few
    task automatic flag_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        fails++;
        if (fails <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    task automatic compare_field(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        if (want_v !== got_v)
            flag_mismatch(what, want_v, got_v);
    endtask

    // advance the motor state by one transaction and build its result
    function automatic t_motion predict_motion(input logic req, input logic idx,
                                               input logic [12:0] spd);
        t_motion         res;
        logic [13:0]     mag;
        logic            run;
        logic [15:0]     per;
        logic [15:0]     left;
        longint unsigned den;
        longint unsigned quo;
        res = '0;
        if (req == REQ_SPEED) begin
            // magnitude, activation and clamp
            mag = spd[12] ? (14'h2000 - {1'b0, spd}) : {1'b0, spd};
            run = (mag >= {1'b0, SPEED_MIN});
            if (!run)
                mag = 14'd1;
            else if (mag > {2'b00, max_cfg})
                mag = {2'b00, max_cfg};
            // period in timer counts, saturating on a zero divisor
            den = 64'd1024 * mag * div_cfg;
            if (den == 0) begin
                per = PER_MAX;
            end else begin
                quo = (64'd2000000 * angle_cfg) / den;
                if (quo < PER_MIN)
                    per = PER_MIN;
                else if (quo > PER_MAX)
                    per = PER_MAX;
                else
                    per = quo[15:0];
            end
            res.period_set = per;
            if (int'(idx) < MOTORS) begin
                active_q[idx] = run;
                if (run)
                    want_dir_q[idx] = !spd[12];
                period_q[idx] = per;
                if (count_q[idx] == 16'd0)
                    count_q[idx] = per;
            end
        end else begin
            // tick: count down, reload and step on underflow
            for (int m = 0; m < MOTORS; m++) begin
                left = count_q[m] - tick_cfg;
                if (left < tick_cfg) begin
                    left = period_q[m];
                    if (active_q[m]) begin
                        if (m < 2)
                            res.step_mask[m] = 1'b1;
                        pin_dir_q[m] = want_dir_q[m];
                    end
                end
                count_q[m] = left;
            end
        end
        for (int m = 0; m < MOTORS && m < 2; m++)
            res.dir_mask[m] = pin_dir_q[m];
        case (div_cfg)
            5'd2:    res.mode_pins = 3'b001;
            5'd4:    res.mode_pins = 3'b010;
            5'd8:    res.mode_pins = 3'b011;
            5'd16:   res.mode_pins = 3'b111;
            default: res.mode_pins = 3'b000;
        endcase
        return res;
    endfunction

    // observe register writes and transactions at each clock edge
    always @(posedge i_clk) begin : watch
        t_motion want;
        if (!i_rst_n) begin
            div_cfg   = 5'd1;
            max_cfg   = 12'd1000;
            angle_cfg = 16'd1843;
            tick_cfg  = 16'd99;
            for (int m = 0; m < MOTORS; m++) begin
                period_q[m]   = '0;
                count_q[m]    = '0;
                active_q[m]   = 1'b0;
                want_dir_q[m] = 1'b0;
                pin_dir_q[m]  = 1'b0;
            end
            pending_motion.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MICROSTEP_DIV: div_cfg   = pwdata[4:0];
                    REG_MAX_SPEED:     max_cfg   = pwdata[11:0];
                    REG_DEG_PER_STEP:  angle_cfg = pwdata[15:0];
                    REG_TICK_AMOUNT:   tick_cfg  = pwdata[15:0];
                    default: ;
                endcase
            end
            // accepted input transaction
            if (i_in_valid && !i_in_stall)
                pending_motion.push_back(predict_motion(i_req_type, i_motor_index, i_speed));
            // accepted result transaction
            if (i_out_valid && !i_out_stall) begin
                steps += $countones(i_step_mask);
                if (pending_motion.size() == 0) begin
                    flag_mismatch("result with none pending (period_set)", 16'd0, i_period_set);
                end else begin
                    want = pending_motion.pop_front();
                    checked++;
                    compare_field("step_mask", want.step_mask, i_step_mask);
                    compare_field("dir_mask", want.dir_mask, i_dir_mask);
                    compare_field("period_set", want.period_set, i_period_set);
                    compare_field("mode_pins", want.mode_pins, i_mode_pins);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_motion.size();
        o_checked    <= checked;
        o_steps      <= steps;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives speed command and tick transactions into the step generator under a
// series of register settings, with random gaps and stalls on both channels,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
    import msp_pkg::*;
    import msp_tb_pkg::*;

    localparam int RUN_LIMIT    = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 155;
    localparam int FIXED_PHASES = 6;
    localparam int RAND_PHASES  = 6;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        req_type    = 1'b0;
    logic        motor_index = 1'b0;
    logic [12:0] speed       = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  step_mask;
    logic [1:0]  dir_mask;
    logic [15:0] period_set;
    logic [2:0]  mode_pins;

    int fail_count;
    int pending;
    int checked;
    int steps;

    // stimulus bookkeeping
    int   cycle_count = 0;
    int   n_speed     = 0;
    int   n_tick      = 0;
    int   n_settings  = 0;
    bit   calm        = 1'b0;
    bit   long_hold   = 1'b0;
    int   cur_max     = 1000;

    // settings for the fixed phases: zero divider, zero speed limit,
    // zero step angle with zero tick, all-high extremes, invalid divider, divider two
    int fix_div  [FIXED_PHASES] = '{0, 4, 8, 16, 31, 2};
    int fix_max  [FIXED_PHASES] = '{4095, 0, 2000, 4095, 10, 600};
    int fix_angle[FIXED_PHASES] = '{1843, 1843, 0, 65535, 1, 1843};
    int fix_tick [FIXED_PHASES] = '{200, 99, 0, 65535, 99, 99};

    // speeds around the activation threshold and the field limits
    int corner_speeds[12] = '{4095, -4096, 0, 9, -9, 10, -10, 1000, -1001, -1, 1, -4095};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_stepper_pulse_generator uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_motor_index (motor_index),
        .i_speed       (speed),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_step_mask   (step_mask),
        .o_dir_mask    (dir_mask),
        .o_period_set  (period_set),
        .o_mode_pins   (mode_pins)
    );

    msp_checker motion_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_motor_index (motor_index),
        .i_speed       (speed),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_step_mask   (step_mask),
        .i_dir_mask    (dir_mask),
        .i_period_set  (period_set),
        .i_mode_pins   (mode_pins),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_steps       (steps)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall before each transaction, one long hold on request
    initial begin : result_sink
        int wait_n;
        forever begin
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_n = calm ? 0 : $urandom_range(0, 5);
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // one input transaction after a random gap
    task automatic drive_item(input logic req, input logic idx, input logic [12:0] spd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        motor_index <= idx;
        speed       <= spd;
        do @(posedge clk); while (in_stall);
        if (req == REQ_SPEED)
            n_speed++;
        else
            n_tick++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input int div, input int top_speed, input int angle,
                                input int tick);
        write_reg(REG_MICROSTEP_DIV, 32'(div));
        write_reg(REG_MAX_SPEED, 32'(top_speed));
        write_reg(REG_DEG_PER_STEP, 32'(angle));
        write_reg(REG_TICK_AMOUNT, 32'(tick));
        cur_max = top_speed;
        n_settings++;
    endtask

    // mostly ticks, with speed commands of several flavors in between
    task automatic run_phase(input bit do_hold, input bit do_pause);
        logic [12:0] spd;
        int          mag;
        bit          neg;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            calm = (k >= 100 && k < 130);
            if (do_hold && k == 40)
                long_hold = 1'b1;
            if (do_pause && k == 70)
                drain_results();
            if ($urandom_range(0, 99) < 75) begin
                drive_item(REQ_TICK, 1'($urandom), 13'($urandom));
            end else begin
                neg = 1'($urandom);
                case ($urandom_range(0, 3))
                    0: spd = 13'($urandom);
                    1: spd = 13'($urandom_range(0, 24)) - 13'd12;
                    2: begin
                        mag = cur_max + int'($urandom_range(0, 2)) - 1;
                        if (mag < 0)
                            mag = 0;
                        if (mag > 4095)
                            mag = 4095;
                        spd = neg ? 13'(-mag) : 13'(mag);
                    end
                    default: begin
                        mag = $urandom_range(10, 600);
                        spd = neg ? 13'(-mag) : 13'(mag);
                    end
                endcase
                drive_item(REQ_SPEED, 1'($urandom), spd);
            end
        end
        calm = 1'b0;
        drain_results();
    endtask

    initial begin : stimulus
        int div;
        int top_speed;
        int angle;
        int tick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corner speeds on alternating motors under reset settings
        for (int i = 0; i < 12; i++) begin
            drive_item(REQ_SPEED, 1'(i), 13'(corner_speeds[i]));
            drive_item(REQ_TICK, 1'(i + 1), (i % 2 == 0) ? 13'h1fff : 13'h0000);
        end
        drain_results();

        // fixed settings covering the special cases and extremes
        for (int p = 0; p < FIXED_PHASES; p++) begin
            apply_config(fix_div[p], fix_max[p], fix_angle[p], fix_tick[p]);
            run_phase(p == FIXED_PHASES - 1, p == 3);
        end

        // random settings, mostly in the useful range
        for (int p = 0; p < RAND_PHASES; p++) begin
            div       = ($urandom_range(0, 3) != 0) ? (1 << $urandom_range(0, 4))
                                                    : $urandom_range(0, 31);
            top_speed = ($urandom_range(0, 7) != 0) ? $urandom_range(10, 4095)
                                                    : $urandom_range(0, 9);
            angle     = ($urandom_range(0, 3) != 0) ? $urandom_range(200, 4000)
                                                    : $urandom_range(0, 65535);
            tick      = ($urandom_range(0, 3) != 0) ? $urandom_range(99, 2000)
                                                    : $urandom_range(0, 65535);
            apply_config(div, top_speed, angle, tick);
            run_phase(1'b0, 1'b0);
        end

        repeat (40) @(posedge clk);
        $display("run covered %0d speed commands and %0d ticks under %0d register settings",
                 n_speed, n_tick, n_settings);
        $display("%0d results compared, %0d step pulses seen, %0d failures",
                 checked, steps, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[multi_stepper_pulse_generator.f]
rtl/msp_pkg.sv
rtl/msp_apb.sv
rtl/msp_ctrl.sv
rtl/msp_dp.sv
rtl/multi_stepper_pulse_generator.sv
dv/msp_tb_pkg.sv
dv/msp_checker.sv
dv/tb_top.sv
